// ===== rtl/anfg_pkg.sv =====
// ----------------------------------------------------------------------------
// anfg_pkg
// Shared types and constants of the Annex B NAL frame gate.
// ----------------------------------------------------------------------------
package anfg_pkg;

    // Frame length limit and the width of a byte position
    localparam int unsigned MAX_FRAME_BYTES = 1048576;
    localparam int          POS_W           = $clog2(MAX_FRAME_BYTES + 1);
    localparam logic [POS_W-1:0] FRAME_LIMIT = POS_W'(MAX_FRAME_BYTES);

    // Fixed field widths
    localparam int LEN_W    = 21;
    localparam int STATUS_W = 3;
    localparam int MODE_W   = 2;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 32;

    // Queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    // Input operation codes
    localparam logic [1:0] OP_BYTE   = 2'd0;
    localparam logic [1:0] OP_MODE   = 2'd1;
    localparam logic [1:0] OP_EMPTY  = 2'd2;
    localparam logic [1:0] OP_IGNORE = 2'd3;

    // Configuration register indexes
    localparam logic CFG_CODEC   = 1'b0;
    localparam logic CFG_PLAYING = 1'b1;

    // Codec modes
    localparam logic [1:0] CODEC_H264 = 2'd0;
    localparam logic [1:0] CODEC_H265 = 2'd1;

    // Result kinds
    localparam logic KIND_VERDICT = 1'b0;
    localparam logic KIND_MODE    = 1'b1;

    // Verdict status codes
    localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_PLAYING = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_START    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NO_SETS     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY       = 3'd4;

    // Remote video modes
    localparam logic [MODE_W-1:0] MODE_VIDEO   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PRIVACY = 2'd1;
    localparam logic [MODE_W-1:0] MODE_HOLD    = 2'd2;

    // NAL type masks
    localparam logic [7:0] AVC_TYPE_MASK  = 8'h1F;
    localparam logic [7:0] HEVC_TYPE_MASK = 8'h3F;

    // H.264 NAL types
    localparam logic [4:0] AVC_SLICE_LO = 5'd1;
    localparam logic [4:0] AVC_SLICE_HI = 5'd4;
    localparam logic [4:0] AVC_IDR      = 5'd5;
    localparam logic [4:0] AVC_SPS      = 5'd7;
    localparam logic [4:0] AVC_PPS      = 5'd8;

    // H.265 NAL types
    localparam logic [5:0] HEVC_IRAP_LO = 6'd16;
    localparam logic [5:0] HEVC_IRAP_HI = 6'd21;
    localparam logic [5:0] HEVC_VPS     = 6'd32;
    localparam logic [5:0] HEVC_SPS     = 6'd33;
    localparam logic [5:0] HEVC_PPS     = 6'd34;

    // Classified item passed from front to back
    typedef struct packed {
        logic [1:0] op;
        logic       first_byte;
        logic       last_byte;
        logic       frame_complete;
        logic       frame_keyframe;
        logic       privacy_on;
        logic       hold_on;
        logic       is_zero;
        logic       is_one;
        logic [4:0] avc_type;
        logic [5:0] hevc_type;
    } item_t;

    // One result item
    typedef struct packed {
        logic                kind;
        logic                forward;
        logic [LEN_W-1:0]    out_length;
        logic                keyframe_out;
        logic                keyframe_request;
        logic [STATUS_W-1:0] status;
        logic [MODE_W-1:0]   remote_mode;
    } result_t;

endpackage

// ===== rtl/annexb_nal_frame_gate_core.sv =====
// ----------------------------------------------------------------------------
// annexb_nal_frame_gate_core
// Annex B frame gate: start-code scan, NAL typing and frame verdicts.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one item per transaction: a frame byte, a privacy/hold
//   update or an empty-frame marker (selected by tuser). Frame bytes come
//   with first/complete/keyframe marks; tlast marks the final byte.
//   m_axis carries one result per frame (verdict) or per update (mode).
//   cfg_we/cfg_index/cfg_data write codec_mode (0) and playing (1); write
//   them only while no transaction is in flight.
// Path: an accepted item is written into the queue and popped by the back end;
//   any result it causes is registered before it is presented on m_axis.
// Throughput: one item per cycle while the result register is free or being
//   taken; the front and back are parted by a four-entry queue.
// Reset: all frame state, flags and configuration clear (H.264, not
//   playing); the queue and the result register empty.
// Stall: while m_axis_tready is low the result register holds, the queue
//   fills, and s_axis_tready drops once four items are waiting.
// ----------------------------------------------------------------------------
module annexb_nal_frame_gate_core
    import anfg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write port
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [1:0]            cfg_data,
    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // data_byte[7:0], first_byte[8], frame_complete[9], frame_keyframe[10],
    // privacy_on[11], hold_on[12], zero[15:13]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // op[1:0]
    input  logic [1:0]            s_axis_tuser,
    // last_byte
    input  logic                  s_axis_tlast,
    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // forward[0], out_length[21:1], keyframe_out[22], keyframe_request[23],
    // status[26:24], remote_mode[28:27], zero[31:29]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // kind[0]
    output logic                  m_axis_tuser
);

    logic    q_full;
    logic    q_push;
    item_t   q_in;
    logic    q_pop;
    logic    q_valid;
    item_t   q_out;
    result_t res;

    // Accept and classify
    anfg_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_item        (q_in)
    );

    // Decouple front and back
    anfg_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_item  (q_out)
    );

    // Scan and decide
    anfg_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_item    (q_out),
        .q_pop     (q_pop),
        .res_valid (m_axis_tvalid),
        .res       (res),
        .res_ready (m_axis_tready)
    );

    // Pack the result
    assign m_axis_tuser = res.kind;
    assign m_axis_tdata = {3'b000, res.remote_mode, res.status, res.keyframe_request,
                           res.keyframe_out, res.out_length, res.forward};

endmodule

// ===== rtl/anfg_front.sv =====
// ----------------------------------------------------------------------------
// anfg_front
// Accepts input transactions, classifies them and pushes them to the queue.
// ----------------------------------------------------------------------------
module anfg_front
    import anfg_pkg::*;
(
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_DATA_W-1:0] s_axis_tdata,
    input  logic [1:0]           s_axis_tuser,
    input  logic                 s_axis_tlast,
    input  logic                 q_full,
    output logic                 q_push,
    output item_t                q_item
);

    logic [7:0] data_byte;
    logic [7:0] hevc_byte;

    // Accept whenever the queue has room
    assign s_axis_tready = ~q_full;

    // Drop ignored operations, push everything else
    assign q_push = s_axis_tvalid & ~q_full & (s_axis_tuser != OP_IGNORE);

    assign data_byte = s_axis_tdata[7:0];
    assign hevc_byte = (data_byte >> 1) & HEVC_TYPE_MASK;

    // Classify the byte and unpack the marks
    always_comb
    begin
        q_item.op             = s_axis_tuser;
        q_item.first_byte     = s_axis_tdata[8];
        q_item.last_byte      = s_axis_tlast;
        q_item.frame_complete = s_axis_tdata[9];
        q_item.frame_keyframe = s_axis_tdata[10];
        q_item.privacy_on     = s_axis_tdata[11];
        q_item.hold_on        = s_axis_tdata[12];
        q_item.is_zero        = (data_byte == 8'h00);
        q_item.is_one         = (data_byte == 8'h01);
        q_item.avc_type       = 5'(data_byte & AVC_TYPE_MASK);
        q_item.hevc_type      = 6'(hevc_byte);
    end

endmodule

// ===== rtl/anfg_queue.sv =====
// ----------------------------------------------------------------------------
// anfg_queue
// Short FIFO of classified items between the front and the back.
// ----------------------------------------------------------------------------
module anfg_queue
    import anfg_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output logic  valid,
    output item_t pop_item
);

    item_t             mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;

    assign full     = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign valid    = (count_reg != '0);
    assign pop_item = mem[rd_ptr_reg];

    // Track occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !(pop && valid))
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && pop && valid)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Store pushed items
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop && valid)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/anfg_back.sv =====
// ----------------------------------------------------------------------------
// anfg_back
// Scans frames for start codes and NAL types, keeps the gate state and
// registers one result per verdict or mode update.
// ----------------------------------------------------------------------------
module anfg_back
    import anfg_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cfg_we,
    input  logic    cfg_index,
    input  logic [1:0] cfg_data,
    input  logic    q_valid,
    input  item_t   q_item,
    output logic    q_pop,
    output logic    res_valid,
    output result_t res,
    input  logic    res_ready
);

    // Configuration
    logic [1:0] codec_mode_reg;
    logic       playing_reg;

    // Gate state
    logic [1:0]       zero_run_reg,   zero_run_next;
    logic [POS_W-1:0] byte_pos_reg,   byte_pos_next;
    logic             expect_hdr_reg, expect_hdr_next;
    logic [POS_W-1:0] last_start_reg, last_start_next;
    logic [POS_W-1:0] trunc_len_reg,  trunc_len_next;
    logic [1:0]       slice_reg,      slice_next;
    logic [2:0]       found_reg,      found_next;
    logic [2:0]       flags_reg,      flags_next;
    logic             sets_sent_reg,  sets_sent_next;
    logic             first_kf_reg,   first_kf_next;
    logic [1:0]       priv_hold_reg,  priv_hold_next;
    logic             kf_pend_reg,    kf_pend_next;

    // Result register
    logic    out_valid_reg, out_valid_next;
    result_t out_res_reg,   out_res_next;

    logic             scan_on;
    logic             is_avc;
    logic             is_hevc;
    logic             cut;
    logic             do_clear;
    logic             do_byte;
    logic             do_verdict;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] len;
    logic [2:0]       need;
    logic [2:0]       full_sets;
    logic             fwd;
    logic [STATUS_W-1:0] status;

    assign q_pop     = q_valid & (~out_valid_reg | res_ready);
    assign res_valid = out_valid_reg;
    assign res       = out_res_reg;
    assign is_avc    = (codec_mode_reg == CODEC_H264);
    assign is_hevc   = (codec_mode_reg == CODEC_H265);

    // Work out the effect of one item on the state and the result
    always_comb
    begin
        zero_run_next   = zero_run_reg;
        byte_pos_next   = byte_pos_reg;
        expect_hdr_next = expect_hdr_reg;
        last_start_next = last_start_reg;
        trunc_len_next  = trunc_len_reg;
        slice_next      = slice_reg;
        found_next      = found_reg;
        flags_next      = flags_reg;
        sets_sent_next  = sets_sent_reg;
        first_kf_next   = first_kf_reg;
        priv_hold_next  = priv_hold_reg;
        kf_pend_next    = kf_pend_reg;
        out_valid_next  = out_valid_reg & ~res_ready;
        out_res_next    = out_res_reg;
        scan_on   = 1'b0;
        cut       = 1'b0;
        pos       = byte_pos_reg;
        len       = '0;
        need      = '0;
        full_sets = '0;
        fwd       = 1'b0;
        status    = ST_OK;
        do_clear   = 1'b0;
        do_byte    = 1'b0;
        do_verdict = 1'b0;

        if (q_pop)
        begin
            case (q_item.op)
                OP_MODE:
                begin
                    do_clear = 1'b0;
                end
                OP_EMPTY:
                begin
                    do_clear   = 1'b1;
                    do_verdict = 1'b1;
                end
                OP_BYTE:
                begin
                    do_clear   = q_item.first_byte;
                    do_byte    = 1'b1;
                    do_verdict = q_item.last_byte;
                end
                default:
                begin
                    do_clear = 1'b0;
                end
            endcase

            // Mode update: clear sets-sent on entering privacy or hold, register a mode result
            if (q_item.op == OP_MODE)
            begin
                if ((q_item.privacy_on && !priv_hold_reg[0]) ||
                    (q_item.hold_on && !priv_hold_reg[1]))
                begin
                    sets_sent_next = 1'b0;
                end
                priv_hold_next = {q_item.hold_on, q_item.privacy_on};
                out_valid_next = 1'b1;
                out_res_next   = '0;
                out_res_next.kind = KIND_MODE;
                if (q_item.hold_on)
                begin
                    out_res_next.remote_mode = MODE_HOLD;
                end
                else if (q_item.privacy_on)
                begin
                    out_res_next.remote_mode = MODE_PRIVACY;
                end
                else
                begin
                    out_res_next.remote_mode = MODE_VIDEO;
                end
            end

            // Start of frame: reset per-frame state, take the marks
            if (do_clear)
            begin
                zero_run_next   = '0;
                byte_pos_next   = '0;
                expect_hdr_next = 1'b0;
                last_start_next = '0;
                trunc_len_next  = '0;
                slice_next      = '0;
                found_next      = '0;
                kf_pend_next    = 1'b0;
                flags_next      = {1'b0, q_item.frame_keyframe, q_item.frame_complete};
            end

            // Scan one byte
            if (do_byte && (byte_pos_next < FRAME_LIMIT))
            begin
                pos           = byte_pos_next;
                byte_pos_next = byte_pos_next + 1'b1;
                scan_on = playing_reg & ~slice_next[1] & (is_avc | is_hevc);
                if (scan_on)
                begin
                    if (expect_hdr_next)
                    begin
                        expect_hdr_next = 1'b0;
                        if (is_avc)
                        begin
                            if (q_item.avc_type == AVC_SPS)
                            begin
                                found_next[1] = 1'b1;
                            end
                            if (q_item.avc_type == AVC_PPS)
                            begin
                                found_next[2] = 1'b1;
                            end
                            if (!flags_next[0] && !slice_next[0])
                            begin
                                if (q_item.avc_type == AVC_IDR)
                                begin
                                    slice_next[0] = 1'b1;
                                    if (first_kf_reg)
                                    begin
                                        slice_next[1]  = 1'b1;
                                        trunc_len_next = last_start_next;
                                        cut            = 1'b1;
                                    end
                                    else
                                    begin
                                        kf_pend_next = 1'b1;
                                    end
                                end
                                else if (q_item.avc_type >= AVC_SLICE_LO &&
                                         q_item.avc_type <= AVC_SLICE_HI)
                                begin
                                    slice_next[0] = 1'b1;
                                end
                            end
                            if (!cut)
                            begin
                                flags_next[2] = 1'b1;
                            end
                        end
                        else
                        begin
                            if (q_item.hevc_type == HEVC_VPS)
                            begin
                                found_next[0] = 1'b1;
                            end
                            if (q_item.hevc_type == HEVC_SPS)
                            begin
                                found_next[1] = 1'b1;
                            end
                            if (q_item.hevc_type == HEVC_PPS)
                            begin
                                found_next[2] = 1'b1;
                            end
                            if (q_item.hevc_type >= HEVC_IRAP_LO &&
                                q_item.hevc_type <= HEVC_IRAP_HI && !flags_next[1])
                            begin
                                flags_next[1] = 1'b1;
                                kf_pend_next  = 1'b1;
                            end
                            flags_next[2] = 1'b1;
                        end
                    end

                    // Track zeros and detect start codes
                    if (!cut)
                    begin
                        if (q_item.is_zero)
                        begin
                            if (zero_run_next != 2'd3)
                            begin
                                zero_run_next = zero_run_next + 1'b1;
                            end
                        end
                        else if (q_item.is_one && zero_run_next[1])
                        begin
                            last_start_next = (zero_run_next == 2'd3) ?
                                              pos - POS_W'(3) : pos - POS_W'(2);
                            expect_hdr_next = 1'b1;
                            zero_run_next   = '0;
                        end
                        else
                        begin
                            zero_run_next = '0;
                        end
                    end
                end
            end

            // Frame verdict
            if (do_verdict)
            begin
                len = slice_next[1] ? trunc_len_next : byte_pos_next;
                if (expect_hdr_next)
                begin
                    flags_next[2] = 1'b1;
                end
                need      = is_avc ? (found_next & 3'b110) : found_next;
                full_sets = is_avc ? 3'b110 : 3'b111;
                if (!playing_reg)
                begin
                    status = ST_NOT_PLAYING;
                end
                else
                begin
                    if ((is_avc || is_hevc) &&
                        ((flags_next[1:0] == 2'b11) || kf_pend_next))
                    begin
                        first_kf_next = 1'b1;
                    end
                    if (len == '0)
                    begin
                        status = ST_EMPTY;
                    end
                    else if (is_avc || is_hevc)
                    begin
                        if (!flags_next[2])
                        begin
                            status = ST_NO_START;
                        end
                        else if (!sets_sent_reg && need == 3'b000)
                        begin
                            status = ST_NO_SETS;
                        end
                        else
                        begin
                            fwd = 1'b1;
                            if (!sets_sent_reg && need == full_sets)
                            begin
                                sets_sent_next = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        fwd = 1'b1;
                    end
                end
                out_valid_next                = 1'b1;
                out_res_next.kind             = KIND_VERDICT;
                out_res_next.forward          = fwd;
                out_res_next.out_length       = LEN_W'(len);
                out_res_next.keyframe_out     = flags_next[1];
                out_res_next.keyframe_request = ~fwd;
                out_res_next.status           = status;
                out_res_next.remote_mode      = MODE_VIDEO;

                // Clear per-frame state after the verdict
                zero_run_next   = '0;
                byte_pos_next   = '0;
                expect_hdr_next = 1'b0;
                last_start_next = '0;
                trunc_len_next  = '0;
                slice_next      = '0;
                found_next      = '0;
                flags_next      = '0;
                kf_pend_next    = 1'b0;
            end
        end
    end

    // Hold the result payload
    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    // Update configuration and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            codec_mode_reg <= CODEC_H264;
            playing_reg    <= 1'b0;
            zero_run_reg   <= '0;
            byte_pos_reg   <= '0;
            expect_hdr_reg <= 1'b0;
            last_start_reg <= '0;
            trunc_len_reg  <= '0;
            slice_reg      <= '0;
            found_reg      <= '0;
            flags_reg      <= '0;
            sets_sent_reg  <= 1'b0;
            first_kf_reg   <= 1'b0;
            priv_hold_reg  <= '0;
            kf_pend_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == CFG_CODEC)
            begin
                codec_mode_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == CFG_PLAYING)
            begin
                playing_reg <= cfg_data[0];
            end
            zero_run_reg   <= zero_run_next;
            byte_pos_reg   <= byte_pos_next;
            expect_hdr_reg <= expect_hdr_next;
            last_start_reg <= last_start_next;
            trunc_len_reg  <= trunc_len_next;
            slice_reg      <= slice_next;
            found_reg      <= found_next;
            flags_reg      <= flags_next;
            sets_sent_reg  <= sets_sent_next;
            first_kf_reg   <= first_kf_next;
            priv_hold_reg  <= priv_hold_next;
            kf_pend_reg    <= kf_pend_next;
            out_valid_reg  <= out_valid_next;
        end
    end

endmodule

// ===== tb/anfg_frame_gate_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anfg_frame_gate_checker
// Watches both streams of the Annex B frame gate and checks every result.
// It follows configuration writes and accepted input transactions. A model
// of the start-code scan, the NAL typing and the frame verdict runs next to
// the block and queues the result each item should cause. Each result
// transaction is checked field by field against the oldest queued one.
// ----------------------------------------------------------------------------
module anfg_frame_gate_checker
    import anfg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [1:0]            cfg_data,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic [1:0]            s_axis_tuser,
    input  logic                  s_axis_tlast,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  m_axis_tuser,
    output int                    fail_count,
    output int                    results_due
);

    // Configuration copy
    logic [1:0]       codec_q;
    logic             playing_q;

    // Frame scan state
    logic [1:0]       zrun;
    logic [POS_W-1:0] bpos;
    logic [POS_W-1:0] start_pos;
    logic [POS_W-1:0] cut_len;
    logic             hdr_due;
    logic             slice_seen;
    logic             cut_done;
    logic [2:0]       sets_found;
    logic             fr_complete;
    logic             fr_key;
    logic             fr_start;
    logic             kf_pending;

    // State that lives across frames
    logic             sets_sent;
    logic             kf_seen;
    logic             privacy;
    logic             hold;

    result_t          awaited[$];
    int               mismatches = 0;
    int               due_n = 0;

    assign fail_count  = mismatches;
    assign results_due = due_n;

    task automatic report(input string what, input int unsigned got,
                          input int unsigned want);
        $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    task automatic clear_frame();
        zrun        = '0;
        bpos        = '0;
        hdr_due     = 1'b0;
        start_pos   = '0;
        cut_len     = '0;
        slice_seen  = 1'b0;
        cut_done    = 1'b0;
        sets_found  = '0;
        fr_complete = 1'b0;
        fr_key      = 1'b0;
        fr_start    = 1'b0;
        kf_pending  = 1'b0;
    endtask

    // Type the NAL unit from its first header byte
    task automatic classify_nal(input logic [7:0] hdr);
        logic [4:0] avc_t;
        logic [5:0] hevc_t;
        avc_t  = 5'(hdr & AVC_TYPE_MASK);
        hevc_t = 6'((hdr >> 1) & HEVC_TYPE_MASK);
        if (codec_q == CODEC_H264)
        begin
            if (avc_t == AVC_SPS) sets_found[1] = 1'b1;
            if (avc_t == AVC_PPS) sets_found[2] = 1'b1;
            // only the first slice of an incomplete frame matters for the cut
            if (!fr_complete && !slice_seen)
            begin
                if (avc_t == AVC_IDR)
                begin
                    slice_seen = 1'b1;
                    if (kf_seen)
                    begin
                        cut_done = 1'b1;
                        cut_len  = start_pos;
                    end
                    else
                    begin
                        kf_pending = 1'b1;
                    end
                end
                else if (avc_t >= AVC_SLICE_LO && avc_t <= AVC_SLICE_HI)
                begin
                    slice_seen = 1'b1;
                end
            end
            if (!cut_done) fr_start = 1'b1;
        end
        else if (codec_q == CODEC_H265)
        begin
            if (hevc_t == HEVC_VPS) sets_found[0] = 1'b1;
            if (hevc_t == HEVC_SPS) sets_found[1] = 1'b1;
            if (hevc_t == HEVC_PPS) sets_found[2] = 1'b1;
            if (hevc_t >= HEVC_IRAP_LO && hevc_t <= HEVC_IRAP_HI && !fr_key)
            begin
                fr_key     = 1'b1;
                kf_pending = 1'b1;
            end
            fr_start = 1'b1;
        end
    endtask

    // Advance the start-code search by one frame byte
    task automatic scan_byte(input logic [7:0] b);
        logic [POS_W-1:0] pos;
        if (bpos < FRAME_LIMIT)
        begin
            pos  = bpos;
            bpos = bpos + 1'b1;
            if (playing_q && !cut_done && codec_q <= CODEC_H265)
            begin
                if (hdr_due)
                begin
                    hdr_due = 1'b0;
                    classify_nal(b);
                end
                if (!cut_done)
                begin
                    if (b == 8'h00)
                    begin
                        if (zrun != 2'd3) zrun = zrun + 1'b1;
                    end
                    else if (b == 8'h01 && zrun >= 2'd2)
                    begin
                        // one extra leading zero belongs to the start code
                        start_pos = pos - ((zrun == 2'd3) ? POS_W'(3) : POS_W'(2));
                        hdr_due   = 1'b1;
                        zrun      = '0;
                    end
                    else
                    begin
                        zrun = '0;
                    end
                end
            end
        end
    endtask

    // Work out the verdict for the frame in hand
    task automatic judge_frame(output result_t r);
        logic [POS_W-1:0]    len;
        logic [2:0]          need;
        logic [2:0]          full;
        logic                fwd;
        logic [STATUS_W-1:0] st;
        fwd = 1'b0;
        st  = ST_OK;
        len = cut_done ? cut_len : bpos;
        // a start code right at the end still counts
        if (hdr_due)
        begin
            fr_start = 1'b1;
            hdr_due  = 1'b0;
        end
        if (!playing_q)
        begin
            st = ST_NOT_PLAYING;
        end
        else
        begin
            if (codec_q <= CODEC_H265)
            begin
                if (fr_complete && fr_key) kf_seen = 1'b1;
                if (kf_pending) kf_seen = 1'b1;
            end
            if (len == '0)
            begin
                st = ST_EMPTY;
            end
            else if (codec_q <= CODEC_H265)
            begin
                need = (codec_q == CODEC_H264) ? (sets_found & 3'b110) : sets_found;
                full = (codec_q == CODEC_H264) ? 3'b110 : 3'b111;
                if (!fr_start)
                begin
                    st = ST_NO_START;
                end
                else if (!sets_sent && need == 3'b000)
                begin
                    st = ST_NO_SETS;
                end
                else
                begin
                    fwd = 1'b1;
                    if (!sets_sent && need == full) sets_sent = 1'b1;
                end
            end
            else
            begin
                fwd = 1'b1;
            end
        end
        r                  = '0;
        r.kind             = KIND_VERDICT;
        r.forward          = fwd;
        r.out_length       = LEN_W'(len);
        r.keyframe_out     = fr_key;
        r.keyframe_request = ~fwd;
        r.status           = st;
        r.remote_mode      = MODE_VIDEO;
    endtask

    // Apply one accepted input transaction
    task automatic take_item(input logic [1:0] op, input logic [IN_DATA_W-1:0] d,
                             input logic last);
        result_t r;
        logic    p;
        logic    h;
        case (op)
            OP_MODE:
            begin
                p = d[11];
                h = d[12];
                if ((p && !privacy) || (h && !hold)) sets_sent = 1'b0;
                privacy       = p;
                hold          = h;
                r             = '0;
                r.kind        = KIND_MODE;
                r.remote_mode = h ? MODE_HOLD : (p ? MODE_PRIVACY : MODE_VIDEO);
                awaited       = {awaited, r};
            end
            OP_EMPTY:
            begin
                clear_frame();
                fr_complete = d[9];
                fr_key      = d[10];
                judge_frame(r);
                awaited = {awaited, r};
                clear_frame();
            end
            OP_BYTE:
            begin
                if (d[8])
                begin
                    clear_frame();
                    fr_complete = d[9];
                    fr_key      = d[10];
                end
                scan_byte(d[7:0]);
                if (last)
                begin
                    judge_frame(r);
                    awaited = {awaited, r};
                    clear_frame();
                end
            end
            default: ; // ignored operation: no effect
        endcase
    endtask

    // Compare one result transaction with the oldest queued one
    task automatic check_result();
        result_t seen;
        result_t want;
        seen.kind             = m_axis_tuser;
        seen.forward          = m_axis_tdata[0];
        seen.out_length       = m_axis_tdata[21:1];
        seen.keyframe_out     = m_axis_tdata[22];
        seen.keyframe_request = m_axis_tdata[23];
        seen.status           = m_axis_tdata[26:24];
        seen.remote_mode      = m_axis_tdata[28:27];
        if (awaited.size() == 0)
        begin
            report("unexpected result, kind", 32'(seen.kind), 0);
        end
        else
        begin
            want = awaited.pop_front();
            if (seen.kind != want.kind)
                report("kind", 32'(seen.kind), 32'(want.kind));
            if (seen.forward != want.forward)
                report("forward", 32'(seen.forward), 32'(want.forward));
            if (seen.out_length != want.out_length)
                report("out_length", 32'(seen.out_length), 32'(want.out_length));
            if (seen.keyframe_out != want.keyframe_out)
                report("keyframe_out", 32'(seen.keyframe_out), 32'(want.keyframe_out));
            if (seen.keyframe_request != want.keyframe_request)
                report("keyframe_request", 32'(seen.keyframe_request),
                       32'(want.keyframe_request));
            if (seen.status != want.status)
                report("status", 32'(seen.status), 32'(want.status));
            if (seen.remote_mode != want.remote_mode)
                report("remote_mode", 32'(seen.remote_mode), 32'(want.remote_mode));
        end
    endtask

    // Follow the block edge by edge
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            codec_q   = CODEC_H264;
            playing_q = 1'b0;
            clear_frame();
            sets_sent = 1'b0;
            kf_seen   = 1'b0;
            privacy   = 1'b0;
            hold      = 1'b0;
            awaited.delete();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready) check_result();
            if (cfg_we)
            begin
                if (cfg_index == CFG_CODEC) codec_q = cfg_data;
                else playing_q = cfg_data[0];
            end
            if (s_axis_tvalid && s_axis_tready)
                take_item(s_axis_tuser, s_axis_tdata, s_axis_tlast);
        end
        due_n = awaited.size();
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the Annex B NAL frame gate.
// A short directed run covers mode updates, an empty frame, an ignored item,
// a frame without start code, a full H.264 frame and a cut at an IDR slice.
// Random phases then send mostly well-formed H.264 / H.265 frames with
// random content, mixed with stray bytes and other items, under all four
// codec values, playing on and off, with random gaps and back-pressure.
// The checker beside the block does the prediction and comparison.
// ----------------------------------------------------------------------------
module tb;
    import anfg_pkg::*;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic                  cfg_index = 1'b0;
    logic [1:0]            cfg_data = 2'd0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [1:0]            s_axis_tuser = OP_BYTE;
    logic                  s_axis_tlast = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;

    int                    fail_count;
    int                    results_due;

    // Sender and receiver controls
    bit                    gaps_on = 1'b1;
    logic                  rx_steady = 1'b0;
    logic                  hold_flip = 1'b0;
    logic                  hold_seen = 1'b0;
    int                    hold_left = 0;
    int                    items_sent = 0;
    logic [1:0]            cur_codec = CODEC_H264;
    logic [7:0]            frame_buf[$];

    annexb_nal_frame_gate_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    anfg_frame_gate_checker gate_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .fail_count    (fail_count),
        .results_due   (results_due)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver: random stalls, steady stretches, and a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_flip != hold_seen)
        begin
            hold_seen = hold_flip;
            hold_left = 60;
        end
        if (hold_left != 0)
        begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= rx_steady || ($urandom_range(99) >= 21);
        end
    end

    // Give up on a hung run
    initial
    begin
        #1_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Offer one item and hold it until the block takes it
    task automatic push_item(input logic [1:0] op, input logic [7:0] data,
                             input logic first, input logic last, input logic comp,
                             input logic key, input logic priv, input logic hold);
        while (gaps_on && ($urandom_range(99) < 21))
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, hold, priv, key, comp, first, data};
        s_axis_tuser  <= op;
        s_axis_tlast  <= last;
        do @(negedge clk); while (!s_axis_tready);
        @(posedge clk);
        if (op != OP_IGNORE) items_sent++;
    endtask

    task automatic send_mode(input logic priv, input logic hold);
        push_item(OP_MODE, 8'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1)),
                  1'($urandom_range(1)), 1'($urandom_range(1)), priv, hold);
    endtask

    task automatic send_empty(input logic comp, input logic key);
        push_item(OP_EMPTY, 8'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1)),
                  comp, key, 1'($urandom_range(1)), 1'($urandom_range(1)));
    endtask

    task automatic send_ignore();
        push_item(OP_IGNORE, 8'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1)),
                  1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                  1'($urandom_range(1)));
    endtask

    // Send the bytes held in frame_buf as one frame
    task automatic send_buf(input logic comp, input logic key, input bit with_last);
        for (int i = 0; i < frame_buf.size(); i++)
            push_item(OP_BYTE, frame_buf[i], i == 0,
                      with_last && (i == frame_buf.size() - 1),
                      (i == 0) ? comp : 1'($urandom_range(1)),
                      (i == 0) ? key : 1'($urandom_range(1)),
                      1'($urandom_range(1)), 1'($urandom_range(1)));
    endtask

    // Pick a NAL header byte for the current codec
    function automatic logic [7:0] pick_header();
        int         r;
        logic [2:0] top3;
        logic [4:0] t5;
        logic [5:0] t6;
        logic [7:0] hdr;
        r    = $urandom_range(99);
        top3 = 3'($urandom_range(7));
        hdr  = 8'($urandom);
        if (cur_codec == CODEC_H264)
        begin
            if (r < 15) t5 = AVC_SPS;
            else if (r < 30) t5 = AVC_PPS;
            else if (r < 60) t5 = AVC_IDR;
            else if (r < 85) t5 = 5'($urandom_range(AVC_SLICE_HI, AVC_SLICE_LO));
            else t5 = 5'($urandom_range(31));
            hdr = {top3, t5};
        end
        else if (cur_codec == CODEC_H265)
        begin
            if (r < 12) t6 = HEVC_VPS;
            else if (r < 24) t6 = HEVC_SPS;
            else if (r < 36) t6 = HEVC_PPS;
            else if (r < 60) t6 = 6'($urandom_range(HEVC_IRAP_HI, HEVC_IRAP_LO));
            else if (r < 80) t6 = 6'($urandom_range(9));
            else t6 = 6'($urandom_range(63));
            hdr = {top3[0], t6, top3[1]};
        end
        return hdr;
    endfunction

    // Append a start code, a header byte and a short payload
    task automatic add_nal(input logic [7:0] hdr, input int plen);
        int r;
        int zeros;
        r     = $urandom_range(9);
        zeros = (r < 6) ? 2 : ((r < 9) ? 3 : 4);
        repeat (zeros) frame_buf = {frame_buf, 8'h00};
        frame_buf = {frame_buf, 8'h01};
        frame_buf = {frame_buf, hdr};
        // bias the payload towards 00 and 01 to provoke near start codes
        repeat (plen)
            frame_buf = {frame_buf, ($urandom_range(3) == 0) ?
                                    8'($urandom_range(1)) : 8'($urandom)};
    endtask

    // Build a small random frame, mostly well formed
    task automatic build_frame();
        int nals;
        frame_buf.delete();
        if ($urandom_range(99) < 6)
        begin
            repeat ($urandom_range(5, 1)) frame_buf = {frame_buf, 8'($urandom)};
        end
        else
        begin
            if ($urandom_range(5) == 0)
                repeat ($urandom_range(2, 1)) frame_buf = {frame_buf, 8'($urandom)};
            nals = $urandom_range(4, 1);
            repeat (nals) add_nal(pick_header(), $urandom_range(5));
            // start code with nothing after it
            if ($urandom_range(11) == 0)
            begin
                frame_buf = {frame_buf, 8'h00, 8'h00, 8'h01};
            end
        end
    endtask

    task automatic cfg_write(input logic idx, input logic [1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Stop sending and wait until every result has come out
    task automatic settle_outputs();
        s_axis_tvalid <= 1'b0;
        do @(negedge clk); while (results_due != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic random_item();
        int r;
        r = $urandom_range(99);
        if (r < 6)
        begin
            send_mode(1'($urandom_range(1)), 1'($urandom_range(1)));
        end
        else if (r < 9)
        begin
            send_empty(1'($urandom_range(1)), 1'($urandom_range(1)));
        end
        else if (r < 11)
        begin
            send_ignore();
        end
        else if (r < 15)
        begin
            // stray bytes with random marks
            repeat ($urandom_range(3, 1))
                push_item(OP_BYTE, 8'($urandom), $urandom_range(4) == 0,
                          $urandom_range(2) == 0, 1'($urandom_range(1)),
                          1'($urandom_range(1)), 1'($urandom_range(1)),
                          1'($urandom_range(1)));
        end
        else
        begin
            build_frame();
            send_buf($urandom_range(99) < 60, 1'($urandom_range(1)),
                     $urandom_range(29) != 0);
        end
    endtask

    initial
    begin
        logic [1:0] codec_val;
        logic       play_val;
        int         stop_at;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: H.264, playing
        cfg_write(CFG_CODEC, CODEC_H264);
        cfg_write(CFG_PLAYING, 2'd1);
        cur_codec = CODEC_H264;
        send_mode(1'b1, 1'b0);
        send_mode(1'b1, 1'b1);
        send_mode(1'b0, 1'b0);
        send_empty(1'b1, 1'b1);
        send_ignore();
        // one byte and no start code
        frame_buf = '{8'hFF};
        send_buf(1'b1, 1'b1, 1'b1);
        // complete keyframe with SPS, PPS and IDR, long start code first
        frame_buf = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h67, 8'h00, 8'h00, 8'h01,
                      8'h68, 8'h00, 8'h00, 8'h01, 8'h65, 8'hAA};
        send_buf(1'b1, 1'b1, 1'b1);
        // incomplete frame led by an IDR slice: cut at its start code
        frame_buf = '{8'hFF, 8'h00, 8'h00, 8'h01, 8'h65};
        send_buf(1'b0, 1'b0, 1'b1);
        settle_outputs();

        // Random phases over codec and playing settings
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: begin codec_val = CODEC_H264; play_val = 1'b1; end
                1: begin codec_val = CODEC_H265; play_val = 1'b1; end
                2: begin codec_val = CODEC_H264; play_val = 1'b0; end
                3: begin codec_val = 2'd2;       play_val = 1'b1; end
                4: begin codec_val = 2'd3;       play_val = 1'b1; end
                5: begin codec_val = CODEC_H265; play_val = 1'b0; end
                6: begin codec_val = CODEC_H264; play_val = 1'b1; end
                default: begin codec_val = CODEC_H265; play_val = 1'b1; end
            endcase
            cfg_write(CFG_CODEC, codec_val);
            cfg_write(CFG_PLAYING, {1'($urandom_range(1)), play_val});
            cur_codec = codec_val;
            // phase 6 runs with neither side idling
            gaps_on = (ph != 6);
            rx_steady <= (ph == 6);
            if (ph == 0 || ph == 7)
            begin
                // hold the receiver off and keep offering results
                hold_flip <= ~hold_flip;
                repeat (12)
                begin
                    if ($urandom_range(1))
                        send_mode(1'($urandom_range(1)), 1'($urandom_range(1)));
                    else
                        send_empty(1'($urandom_range(1)), 1'($urandom_range(1)));
                end
            end
            stop_at = items_sent + 190;
            while (items_sent < stop_at) random_item();
            settle_outputs();
        end

        if (fail_count == 0 && results_due == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/anfg_pkg.sv
rtl/anfg_front.sv
rtl/anfg_queue.sv
rtl/anfg_back.sv
rtl/annexb_nal_frame_gate_core.sv
tb/anfg_frame_gate_checker.sv
tb/tb.sv
